// ===== src/mmr_pkg.sv =====
// ============================================================================
// mmr_pkg - shared types and constants for the row matrix multiplier
// Request and result payloads, opcodes, and the command/status structs
// that join the controller and the datapath.
// ============================================================================
`default_nettype none

package mmr_pkg;

    localparam int MAX_DIM_DEF = 16;   // default store size (rows and columns)
    localparam int FIELD_DIM   = 16;   // reach of the 4-bit row/col fields
    localparam int IDX_W       = 4;    // width of row and column fields
    localparam int DIM_W       = 5;    // width of the dim register
    localparam int VAL_W       = 16;   // Q8.8 element
    localparam int PROD_W      = 32;   // Q16.16 product
    localparam int ACC_W       = 40;   // Q24.16 sum

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

    localparam logic [1:0] OP_WR_A    = 2'd0;
    localparam logic [1:0] OP_WR_B    = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]              op;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [ACC_W-1:0] product_sum;
        logic                    last;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic                    wr_a;
        logic                    wr_b;
        logic [IDX_W-1:0]        wr_row;
        logic [IDX_W-1:0]        wr_col;
        logic signed [VAL_W-1:0] wr_value;
        logic                    mac_issue;
        logic                    mac_first;
        logic                    mac_last;
        logic [IDX_W-1:0]        mac_row;
        logic [IDX_W-1:0]        mac_k;
        logic [IDX_W-1:0]        mac_col;
        logic                    mac_end;    // final column of the row
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_taken;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/mmr_datapath.sv =====
// ============================================================================
// mmr_datapath - element stores, MAC pipeline and result buffer
// Two element memories, a registered read stage, a registered multiplier,
// an accumulator and a two-slot output buffer (output register plus hold).
// ============================================================================
`default_nettype none

module mmr_datapath
    import mmr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_rsp
);

    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = 1 << (2 * AW);

    logic [VAL_W-1:0] mem_a [DEPTH];
    logic [VAL_W-1:0] mem_b [DEPTH];

    logic [2*AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

    // stage 1: read data
    logic signed [VAL_W-1:0] r_a_rd, r_b_rd;
    logic                    r_s1_v, r_s1_first, r_s1_last;
    logic [IDX_W-1:0]        r_s1_row, r_s1_col;
    logic                    r_s1_end;
    // stage 2: product
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_s2_v, r_s2_first, r_s2_last;
    logic [IDX_W-1:0]         r_s2_row, r_s2_col;
    logic                     r_s2_end;
    // stage 3: accumulate
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic                     push;
    t_rsp                     res;
    // result buffer
    t_rsp r_out, r_hold;
    logic r_out_v, r_hold_v;
    logic take, out_free;

    assign wr_addr   = {AW'(i_cmd.wr_row), AW'(i_cmd.wr_col)};
    assign rd_addr_a = {AW'(i_cmd.mac_row), AW'(i_cmd.mac_k)};
    assign rd_addr_b = {AW'(i_cmd.mac_k), AW'(i_cmd.mac_col)};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            mem_a[wr_addr] <= i_cmd.wr_value;
        end
        if (i_cmd.wr_b) begin
            mem_b[wr_addr] <= i_cmd.wr_value;
        end
        if (i_cmd.mac_issue) begin
            r_a_rd <= mem_a[rd_addr_a];
            r_b_rd <= mem_b[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.mac_first;
        r_s1_last  <= i_cmd.mac_last;
        r_s1_row   <= i_cmd.mac_row;
        r_s1_col   <= i_cmd.mac_col;
        r_s1_end   <= i_cmd.mac_end;
        r_prod     <= r_a_rd * r_b_rd;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_row   <= r_s1_row;
        r_s2_col   <= r_s1_col;
        r_s2_end   <= r_s1_end;
        if (r_s2_v) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.mac_issue;
            r_s2_v <= r_s1_v;
        end
    end

    always_comb begin
        n_acc           = (r_s2_first ? '0 : r_acc) + ACC_W'(r_prod);
        push            = r_s2_v & r_s2_last;
        res.out_row     = r_s2_row;
        res.out_col     = r_s2_col;
        res.product_sum = n_acc;
        res.last        = r_s2_end;
    end

    assign take     = r_out_v & ~i_out_stall;
    assign out_free = ~r_out_v | take;

    // The controller never starts a column unless a slot will be left for it,
    // so a push never meets a full buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
        end else if (out_free) begin
            if (r_hold_v) begin
                r_out    <= r_hold;
                r_out_v  <= 1'b1;
                r_hold   <= res;
                r_hold_v <= push;
            end else begin
                r_out    <= res;
                r_out_v  <= push;
            end
        end else if (push) begin
            r_hold   <= res;
            r_hold_v <= 1'b1;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_rsp           = r_out;
    assign o_sts.out_taken = take;

endmodule

`default_nettype wire

// ===== src/mmr_ctrl.sv =====
// ============================================================================
// mmr_ctrl - request decode and MAC sequencer
// Holds the dim register, decodes requests and steps column and k counters
// for a compute request, throttled by the free slots of the result buffer.
// ============================================================================
`default_nettype none

module mmr_ctrl
    import mmr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_req             i_req,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [DIM_W-1:0] i_cfg_dim,
    input  wire t_sts             i_sts,
    output t_cmd                  o_cmd
);

    localparam int MAXN = (MAX_DIM < FIELD_DIM) ? MAX_DIM : FIELD_DIM;
    localparam logic [DIM_W-1:0] MAXN_V    = DIM_W'(MAXN);
    localparam logic [6:0]       MAX_DIM_V = 7'(MAX_DIM);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             r_state, n_state;
    logic [DIM_W-1:0] r_dim;
    logic [IDX_W-1:0] r_nlast, n_nlast;     // effective dim minus one
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_k, n_k;
    logic [1:0]       r_pend, n_pend;       // columns started, result not taken
    logic [IDX_W-1:0] eff_last;
    logic             accept, in_store, issue, first, klast;

    always_comb begin
        priority if (r_dim == '0) begin
            eff_last = '0;
        end else if (r_dim > MAXN_V) begin
            eff_last = IDX_W'(MAXN - 1);
        end else begin
            eff_last = IDX_W'(r_dim - 1'b1);
        end
    end

    assign accept   = i_in_valid & ~o_in_stall;
    assign in_store = ({3'b000, i_req.row} < MAX_DIM_V) & ({3'b000, i_req.col} < MAX_DIM_V);
    assign first    = (r_k == '0);
    assign klast    = (r_k == r_nlast);
    // start a column only when a buffer slot is sure to be free
    assign issue    = (r_state == ST_RUN) & (~first | (r_pend != 2'd2) | i_sts.out_taken);

    always_comb begin
        n_state = r_state;
        n_nlast = r_nlast;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_req.op == OP_COMPUTE && i_req.row <= eff_last) begin
                    n_state = ST_RUN;
                    n_nlast = eff_last;
                    n_row   = i_req.row;
                    n_col   = '0;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (klast) begin
                        n_k   = '0;
                        n_col = r_col + 1'b1;
                        if (r_col == r_nlast) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_pend = r_pend + {1'b0, issue & first} - {1'b0, i_sts.out_taken};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_dim   <= DIM_RESET;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            if (i_cfg_valid) begin
                r_dim <= i_cfg_dim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nlast <= n_nlast;
        r_row   <= n_row;
        r_col   <= n_col;
        r_k     <= n_k;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_cmd.wr_a      = accept & in_store & (i_req.op == OP_WR_A);
        o_cmd.wr_b      = accept & in_store & (i_req.op == OP_WR_B);
        o_cmd.wr_row    = i_req.row;
        o_cmd.wr_col    = i_req.col;
        o_cmd.wr_value  = i_req.value;
        o_cmd.mac_issue = issue;
        o_cmd.mac_first = first;
        o_cmd.mac_last  = klast;
        o_cmd.mac_row   = r_row;
        o_cmd.mac_k     = r_k;
        o_cmd.mac_col   = r_col;
        o_cmd.mac_end   = (r_col == r_nlast);
    end

endmodule

`default_nettype wire

// ===== src/matrix_multiply_rows_core.sv =====
// ============================================================================
// matrix_multiply_rows_core - row-at-a-time square matrix multiplier
// Q8.8 elements of A and B are loaded one at a time; a compute request
// streams one row of C = A x B as Q24.16 sums.
// ============================================================================
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_req): op 0 writes A[row][col],
//   op 1 writes B[row][col], op 2 computes row 'row' of C. A write never
//   blocks. A compute holds o_in_stall until its last multiply-accumulate
//   (n = effective dim, n*n of them) is issued on the single MAC unit; one
//   element pair is read per cycle from each store unless the sequencer pauses.
//   Result channel (o_out_valid / i_out_stall / o_rsp): n results per compute,
//   column 0 first, last set on column n-1. Each result leaves the accumulator
//   for the result buffer once the last product of its column is summed.
//   A two-slot result buffer lets the next column run while a result waits;
//   under a long stall the sequencer pauses at a column boundary, nothing lost.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_dim): write dim only
//   while no compute is in flight. Dim 0 acts as 1, above the store as max.
//   Reset (synchronous, active low) clears control and sets dim to 16; the
//   element stores keep no reset value and must be written before use.
// ============================================================================
`default_nettype none

module matrix_multiply_rows_core
    import mmr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request channel
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_req             i_req,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_rsp                  o_rsp,
    // dim register write
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [DIM_W-1:0] i_cfg_dim
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: decode requests, step column and k counters
    mmr_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_dim   (i_cfg_dim),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // stores, MAC pipeline and result buffer
    mmr_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTH
    // MAC issue happens only while requests are held off
    a_issue_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mac_issue |-> o_in_stall)
        else $error("MAC issued while request channel open");

    // a store write never shares a cycle with a MAC read
    a_write_not_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_a || cmd.wr_b) |-> !cmd.mac_issue)
        else $error("element write during compute");

    // a write request leaves the channel open next cycle
    a_write_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_req.op == OP_WR_A || i_req.op == OP_WR_B))
        |=> !o_in_stall)
        else $error("write request blocked the channel");

    // a stalled result holds valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_rsp)))
        else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
